@@ src/ltu_pkg.sv @@
// ----------------------------------------------------------------------------
// ltu_pkg
// Shared types, ellipsoid constants and elaboration-time helpers for the
// latitude/longitude to UTM pipeline. Most fractions are signed Q56; DRAD is unsigned Q0.64.
// ----------------------------------------------------------------------------
package ltu_pkg;

    typedef struct packed {
        logic signed [30:0] latitude;
        logic signed [31:0] longitude;
    } coord_t;

    typedef struct packed {
        logic [5:0]  utm_zone;
        logic        is_north;
        logic [29:0] easting_mm;
        logic [33:0] northing_mm;
    } result_t;

    typedef struct packed {
        logic signed [63:0] ts;
        logic signed [63:0] ss;
        logic signed [63:0] tc;
        logic signed [63:0] sc;
        logic signed [63:0] x2;
    } trig_t;

    localparam int QB = 56;
    localparam int SCALE_BITS = 26;

    function automatic logic [63:0] frac_bits(logic [63:0] num, logic [63:0] den, int bits);
        logic [63:0] q;
        logic [63:0] rem;
        q = '0;
        rem = num;
        for (int i = 0; i < bits; i++)
        begin
            rem = rem << 1;
            q = q << 1;
            if (rem >= den)
            begin
                rem = rem - den;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic signed [63:0] cqm(logic signed [63:0] a, logic signed [63:0] b);
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [127:0] p;
        logic [63:0]  r;
        ua = a[63] ? 64'(-a) : 64'(a);
        ub = b[63] ? 64'(-b) : 64'(b);
        p = {64'd0, ua} * {64'd0, ub};
        p = p + (128'd1 << (QB - 1));
        r = p[QB+63:QB];
        return (a[63] ^ b[63]) ? $signed(-r) : $signed(r);
    endfunction

    localparam logic signed [63:0] ONE  = 64'sh0100_0000_0000_0000;
    localparam logic signed [63:0] HALF = ONE >>> 1;
    localparam logic [63:0] DRAD = frac_bits(64'd17453292519943296,
                                             64'd1000000000000000000, 64);
    localparam logic signed [63:0] FLAT = $signed(frac_bits(64'd1000000000,
                                                            64'd298257223563, QB));
    localparam logic signed [63:0] E2 = cqm(FLAT, 2 * ONE - FLAT);
    localparam logic signed [63:0] E4 = cqm(E2, E2);
    localparam logic signed [63:0] E6 = cqm(E4, E2);
    localparam logic signed [63:0] EP = $signed(frac_bits(64'(E2), 64'(ONE - E2), QB));
    localparam logic signed [63:0] EP2 = cqm(EP, EP);
    localparam logic signed [63:0] M0 = ONE - E2 / 4 - 3 * E4 / 64 - 5 * E6 / 256;
    localparam logic signed [63:0] M2 = 3 * E2 / 8 + 3 * E4 / 32 + 45 * E6 / 1024;
    localparam logic signed [63:0] M4 = 15 * E4 / 256 + 45 * E6 / 1024;
    localparam logic signed [63:0] M6 = 35 * E6 / 3072;
    localparam logic signed [63:0] H1 = ONE >>> 1;
    localparam logic signed [63:0] H2 = 3 * (ONE >>> 3);
    localparam logic signed [63:0] H3 = 5 * (ONE >>> 4);
    localparam logic signed [63:0] H4 = 35 * (ONE >>> 7);
    localparam logic signed [63:0] H5 = 63 * (ONE >>> 8);
    localparam logic signed [63:0] SQ =
        (64'sd63755857452 * (64'sd1 <<< SCALE_BITS) + 64'sd5) / 64'sd10;
    localparam logic signed [63:0] FALSE_EAST  = 64'sd500000000;
    localparam logic signed [63:0] EAST_MAX    = 64'sd1000000000;
    localparam logic signed [63:0] NORTH_MAX   = 64'sd10000000000;

endpackage

@@ src/latlon_to_utm_unit.sv @@
// ----------------------------------------------------------------------------
// latlon_to_utm_unit
// WGS84 latitude/longitude to UTM zone, hemisphere, easting and northing.
// The delay from transfer to done is set by a chain of multiply phases,
//   mostly the 13-step sine/cosine series chain, plus the output
//   register.
// Throughput: one item per cycle; busy is always low.
// Reset clears only the valid pipeline; done stays low until results arrive.
// ----------------------------------------------------------------------------
module latlon_to_utm_unit #(
    parameter int ANGLE_FRAC_BITS = 23
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  ltu_pkg::coord_t  coord,
    output logic             done,
    output ltu_pkg::result_t result
);
    import ltu_pkg::*;

    localparam int PH = 3;
    localparam int PIPE_CYCLES = 51 * PH;
    localparam int DSH = 8 + ANGLE_FRAC_BITS;
    localparam logic signed [63:0] LIM_LAT = 64'sd90 <<< ANGLE_FRAC_BITS;
    localparam logic signed [63:0] LIM_LON = 64'sd180 <<< ANGLE_FRAC_BITS;

    logic signed [63:0] lat_x, lon_x, lat_c, lon_c, lon_off, center;
    logic [63:0]        lon_sh;
    logic [19:0]        zprod;
    logic [6:0]         zraw;
    logic [5:0]         zone;
    logic signed [63:0] lat_reg, lonrel_reg;
    logic [5:0]         zone_reg;
    logic               north_reg;
    logic               v0_reg;
    logic [PIPE_CYCLES-1:0] vpipe_reg;

    logic signed [63:0] phi, l, phi_d, x2, mm0, l41, s, c;
    logic signed [63:0] s2, c2, sc, l2, lc, sin2, cos2;
    logic signed [63:0] c4, s4, sc2, l4, xx, sin4p, sin4, ssq, t2, scl2;
    logic signed [63:0] c2_d1, sin2_d1, sin2_d2, c6, epc4, t6a, sin6, t4, h5, cos2_d2;
    logic signed [63:0] epc6, ep2c6, t6, h4, x_d1, x_d2, x_d3, x_d4;
    logic signed [63:0] c4_d2, sc2_d2, s4_d2, epc4_d1, c2_d3, s2_d3, mm0_d, t2_d2, t4_d1;
    logic signed [63:0] marc, marc_d, e3in, e5in, n4in, n6in, e3, e5, n4, n6;
    logic signed [63:0] h3, h2, h1, w, w_d1, l2_d4, l2_d5, l4_d4;
    logic signed [63:0] le3, le3_d1, le5, ln4, ln6, ebi, nbi, lc_d6, scl2_d5, eb, nb;
    logic signed [63:0] east, wnb, north, emm, nmm, e_sum, n_sum, e_sat, n_sat;
    logic [5:0]         zone_d;
    logic               north_d;
    trig_t              stage [14];
    result_t            result_reg;
    logic               done_reg;

    assign busy = 1'b0;

    always_comb
    begin
        lat_x = {{33{coord.latitude[30]}}, coord.latitude};
        lon_x = {{32{coord.longitude[31]}}, coord.longitude};
        lat_c = (lat_x > LIM_LAT) ? LIM_LAT : ((lat_x < -LIM_LAT) ? -LIM_LAT : lat_x);
        lon_c = (lon_x > LIM_LON) ? LIM_LON : ((lon_x < -LIM_LON) ? -LIM_LON : lon_x);
        lon_off = lon_c + LIM_LON;
        lon_sh = 64'(lon_off) >> ANGLE_FRAC_BITS;
        zprod = 20'(lon_sh[8:0]) * 20'd683;
        zraw = {1'b0, zprod[17:12]} + 7'd1;
        zone = (zraw > 7'd60) ? 6'd60 : zraw[5:0];
        center = (64'(zone) * 64'sd6 - 64'sd183) <<< ANGLE_FRAC_BITS;
    end

    always_ff @(posedge clk)
    begin
        lat_reg    <= lat_c;
        lonrel_reg <= lon_c - center;
        zone_reg   <= zone;
        north_reg  <= ~lat_c[63];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg    <= 1'b0;
            vpipe_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            v0_reg    <= start;
            vpipe_reg <= {vpipe_reg[PIPE_CYCLES-2:0], v0_reg};
            done_reg  <= vpipe_reg[PIPE_CYCLES-1];
        end
    end

    ltu_mul #(.SH(DSH)) u_phi (.clk(clk), .a(lat_reg), .b($signed(DRAD)), .p(phi));
    ltu_mul #(.SH(DSH)) u_l (.clk(clk), .a(lonrel_reg), .b($signed(DRAD)), .p(l));
    ltu_mul #(.SH(QB)) u_x2 (.clk(clk), .a(phi), .b(phi), .p(x2));
    ltu_mul #(.SH(QB)) u_mm0 (.clk(clk), .a(M0), .b(phi), .p(mm0));
    ltu_dly #(.W(64), .N(PH)) u_phid (.clk(clk), .d(phi), .q(phi_d));
    ltu_dly #(.W(64), .N(40 * PH)) u_l41 (.clk(clk), .d(l), .q(l41));
    ltu_dly #(.W(64), .N(43 * PH)) u_mm0d (.clk(clk), .d(mm0), .q(mm0_d));
    ltu_dly #(.W(6), .N(PIPE_CYCLES)) u_zd (.clk(clk), .d(zone_reg), .q(zone_d));
    ltu_dly #(.W(1), .N(PIPE_CYCLES)) u_nd (.clk(clk), .d(north_reg), .q(north_d));

    always_comb
    begin
        stage[0].ts = phi_d;
        stage[0].ss = phi_d;
        stage[0].tc = ONE;
        stage[0].sc = ONE;
        stage[0].x2 = x2;
    end

    for (genvar k = 1; k <= 13; k++)
    begin : g_trig
        ltu_trig_step #(.K(k)) u_step (.clk(clk), .din(stage[k-1]), .dout(stage[k]));
    end

    assign s = stage[13].ss;
    assign c = stage[13].sc;

    ltu_mul #(.SH(QB)) u_s2 (.clk(clk), .a(s), .b(s), .p(s2));
    ltu_mul #(.SH(QB)) u_c2 (.clk(clk), .a(c), .b(c), .p(c2));
    ltu_mul #(.SH(QB)) u_sc (.clk(clk), .a(s), .b(c), .p(sc));
    ltu_mul #(.SH(QB)) u_l2 (.clk(clk), .a(l41), .b(l41), .p(l2));
    ltu_mul #(.SH(QB)) u_lc (.clk(clk), .a(l41), .b(c), .p(lc));

    assign sin2 = 64'sd2 * sc;
    assign cos2 = c2 - s2;

    ltu_mul #(.SH(QB)) u_c4 (.clk(clk), .a(c2), .b(c2), .p(c4));
    ltu_mul #(.SH(QB)) u_s4 (.clk(clk), .a(s2), .b(s2), .p(s4));
    ltu_mul #(.SH(QB)) u_sc2 (.clk(clk), .a(s2), .b(c2), .p(sc2));
    ltu_mul #(.SH(QB)) u_l4 (.clk(clk), .a(l2), .b(l2), .p(l4));
    ltu_mul #(.SH(QB)) u_xx (.clk(clk), .a(E2), .b(s2), .p(xx));
    ltu_mul #(.SH(QB)) u_s4p (.clk(clk), .a(sin2), .b(cos2), .p(sin4p));
    ltu_mul #(.SH(QB)) u_ssq (.clk(clk), .a(sin2), .b(sin2), .p(ssq));
    ltu_mul #(.SH(QB)) u_t2 (.clk(clk), .a(M2), .b(sin2), .p(t2));
    ltu_mul #(.SH(QB)) u_scl2 (.clk(clk), .a(sc), .b(l2), .p(scl2));
    ltu_dly #(.W(64), .N(PH)) u_c2d1 (.clk(clk), .d(c2), .q(c2_d1));
    ltu_dly #(.W(64), .N(PH)) u_s2a (.clk(clk), .d(sin2), .q(sin2_d1));
    ltu_dly #(.W(64), .N(PH)) u_s2b (.clk(clk), .d(sin2_d1), .q(sin2_d2));
    ltu_dly #(.W(64), .N(2 * PH)) u_cos2d (.clk(clk), .d(cos2), .q(cos2_d2));
    ltu_dly #(.W(64), .N(3 * PH)) u_c2d3 (.clk(clk), .d(c2), .q(c2_d3));
    ltu_dly #(.W(64), .N(3 * PH)) u_s2d3 (.clk(clk), .d(s2), .q(s2_d3));

    assign sin4 = 64'sd2 * sin4p;

    ltu_mul #(.SH(QB)) u_c6 (.clk(clk), .a(c4), .b(c2_d1), .p(c6));
    ltu_mul #(.SH(QB)) u_epc4 (.clk(clk), .a(EP), .b(c4), .p(epc4));
    ltu_mul #(.SH(QB)) u_t6a (.clk(clk), .a(ssq), .b(sin2_d1), .p(t6a));
    ltu_mul #(.SH(QB)) u_t4 (.clk(clk), .a(M4), .b(sin4), .p(t4));
    ltu_mul #(.SH(QB)) u_h5 (.clk(clk), .a(xx), .b(H5), .p(h5));
    ltu_dly #(.W(64), .N(PH)) u_xd1 (.clk(clk), .d(xx), .q(x_d1));
    ltu_dly #(.W(64), .N(PH)) u_xd2 (.clk(clk), .d(x_d1), .q(x_d2));
    ltu_dly #(.W(64), .N(PH)) u_xd3 (.clk(clk), .d(x_d2), .q(x_d3));
    ltu_dly #(.W(64), .N(PH)) u_xd4 (.clk(clk), .d(x_d3), .q(x_d4));
    ltu_dly #(.W(64), .N(2 * PH)) u_c4d (.clk(clk), .d(c4), .q(c4_d2));
    ltu_dly #(.W(64), .N(2 * PH)) u_sc2d (.clk(clk), .d(sc2), .q(sc2_d2));
    ltu_dly #(.W(64), .N(2 * PH)) u_s4d (.clk(clk), .d(s4), .q(s4_d2));
    ltu_dly #(.W(64), .N(2 * PH)) u_t2d (.clk(clk), .d(t2), .q(t2_d2));
    ltu_dly #(.W(64), .N(4 * PH)) u_l2d4 (.clk(clk), .d(l2), .q(l2_d4));
    ltu_dly #(.W(64), .N(PH)) u_l2d5 (.clk(clk), .d(l2_d4), .q(l2_d5));
    ltu_dly #(.W(64), .N(4 * PH)) u_l4d (.clk(clk), .d(l4), .q(l4_d4));
    ltu_dly #(.W(64), .N(5 * PH)) u_scl2d (.clk(clk), .d(scl2), .q(scl2_d5));
    ltu_dly #(.W(64), .N(6 * PH)) u_lcd (.clk(clk), .d(lc), .q(lc_d6));

    assign sin6 = 64'sd3 * sin2_d2 - 64'sd4 * t6a;
    assign e3in = cos2_d2 + epc4;

    ltu_mul #(.SH(QB)) u_epc6 (.clk(clk), .a(EP), .b(c6), .p(epc6));
    ltu_mul #(.SH(QB)) u_ep2c6 (.clk(clk), .a(EP2), .b(c6), .p(ep2c6));
    ltu_mul #(.SH(QB)) u_t6 (.clk(clk), .a(M6), .b(sin6), .p(t6));
    ltu_mul #(.SH(QB)) u_h4 (.clk(clk), .a(x_d1), .b(H4 + h5), .p(h4));
    ltu_dly #(.W(64), .N(PH)) u_epc4d (.clk(clk), .d(epc4), .q(epc4_d1));
    ltu_dly #(.W(64), .N(PH)) u_t4d (.clk(clk), .d(t4), .q(t4_d1));
    ltu_div #(.DIVISOR(6), .NEG(1'b0)) u_e3 (.clk(clk), .x(e3in), .q(e3));

    always_comb
    begin
        marc = mm0_d - t2_d2 + t4_d1 - t6;
        e5in = 64'sd5 * c4_d2 - 64'sd18 * sc2_d2 + s4_d2 + 64'sd72 * epc6
             - 64'sd58 * epc4_d1;
        n4in = 64'sd5 * c2_d3 - s2_d3 + 64'sd9 * epc4_d1 + 64'sd4 * ep2c6;
        n6in = 64'sd61 * c4_d2 - 64'sd58 * sc2_d2 + s4_d2 + 64'sd600 * epc6
             - 64'sd330 * epc4_d1;
    end

    ltu_dly #(.W(64), .N(5 * PH)) u_marcd (.clk(clk), .d(marc), .q(marc_d));
    ltu_div #(.DIVISOR(120), .NEG(1'b0)) u_e5 (.clk(clk), .x(e5in), .q(e5));
    ltu_div #(.DIVISOR(24), .NEG(1'b0)) u_n4 (.clk(clk), .x(n4in), .q(n4));
    ltu_div #(.DIVISOR(720), .NEG(1'b0)) u_n6 (.clk(clk), .x(n6in), .q(n6));
    ltu_mul #(.SH(QB)) u_h3 (.clk(clk), .a(x_d2), .b(H3 + h4), .p(h3));
    ltu_mul #(.SH(QB)) u_h2 (.clk(clk), .a(x_d3), .b(H2 + h3), .p(h2));
    ltu_mul #(.SH(QB)) u_h1 (.clk(clk), .a(x_d4), .b(H1 + h2), .p(h1));

    assign w = ONE + h1;

    ltu_mul #(.SH(QB)) u_le3 (.clk(clk), .a(l2_d4), .b(e3), .p(le3));
    ltu_dly #(.W(64), .N(PH)) u_le3d (.clk(clk), .d(le3), .q(le3_d1));
    ltu_mul #(.SH(QB)) u_le5 (.clk(clk), .a(l4_d4), .b(e5), .p(le5));
    ltu_mul #(.SH(QB)) u_ln4 (.clk(clk), .a(l2_d5), .b(n4), .p(ln4));
    ltu_mul #(.SH(QB)) u_ln6 (.clk(clk), .a(l4_d4), .b(n6), .p(ln6));

    assign ebi = ONE + le3_d1 + le5;
    assign nbi = HALF + ln4 + ln6;

    ltu_mul #(.SH(QB)) u_eb (.clk(clk), .a(lc_d6), .b(ebi), .p(eb));
    ltu_mul #(.SH(QB)) u_nb (.clk(clk), .a(scl2_d5), .b(nbi), .p(nb));
    ltu_dly #(.W(64), .N(PH)) u_wd (.clk(clk), .d(w), .q(w_d1));
    ltu_mul #(.SH(QB)) u_east (.clk(clk), .a(w_d1), .b(eb), .p(east));
    ltu_mul #(.SH(QB)) u_wnb (.clk(clk), .a(w_d1), .b(nb), .p(wnb));

    assign north = marc_d + wnb;

    ltu_mul #(.SH(QB + SCALE_BITS)) u_emm (.clk(clk), .a(east), .b(SQ), .p(emm));
    ltu_mul #(.SH(QB + SCALE_BITS)) u_nmm (.clk(clk), .a(north), .b(SQ), .p(nmm));

    always_comb
    begin
        e_sum = emm + FALSE_EAST;
        n_sum = north_d ? nmm : (nmm + NORTH_MAX);
        e_sat = (e_sum < 0) ? 64'sd0 : ((e_sum > EAST_MAX) ? EAST_MAX : e_sum);
        n_sat = (n_sum < 0) ? 64'sd0 : ((n_sum > NORTH_MAX) ? NORTH_MAX : n_sum);
    end

    always_ff @(posedge clk)
    begin
        result_reg.utm_zone    <= zone_d;
        result_reg.is_north    <= north_d;
        result_reg.easting_mm  <= e_sat[29:0];
        result_reg.northing_mm <= n_sat[33:0];
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##(PIPE_CYCLES + 2) done)
        else $error("transfer did not produce done");
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        !start |-> ##(PIPE_CYCLES + 2) !done)
        else $error("done without transfer");
    a_zone: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.utm_zone >= 6'd1 && result.utm_zone <= 6'd60))
        else $error("zone out of range");
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.easting_mm <= 30'd1000000000
                  && result.northing_mm <= 34'd10000000000))
        else $error("coordinate not saturated");
endmodule

@@ src/ltu_dly.sv @@
// ----------------------------------------------------------------------------
// ltu_dly
// Fixed-length register delay line used to align operands between stages.
// ----------------------------------------------------------------------------
module ltu_dly #(
    parameter int W = 64,
    parameter int N = 3
) (
    input  logic         clk,
    input  logic [W-1:0] d,
    output logic [W-1:0] q
);
    logic [W-1:0] tap_reg [N];

    always_ff @(posedge clk)
    begin
        tap_reg[0] <= d;
        for (int i = 1; i < N; i++)
        begin
            tap_reg[i] <= tap_reg[i-1];
        end
    end

    assign q = tap_reg[N-1];
endmodule

@@ src/ltu_mul.sv @@
// ----------------------------------------------------------------------------
// ltu_mul
// Three-stage signed 64x64 multiplier: magnitude, 32x32-bit partial products,
// then sum, round half away from zero, shift right by SH and restore sign.
// ----------------------------------------------------------------------------
module ltu_mul #(
    parameter int SH = 56
) (
    input  logic               clk,
    input  logic signed [63:0] a,
    input  logic signed [63:0] b,
    output logic signed [63:0] p
);
    logic [63:0]  ma_reg;
    logic [63:0]  mb_reg;
    logic         neg1_reg;
    logic [63:0]  pp00_reg;
    logic [63:0]  pp01_reg;
    logic [63:0]  pp10_reg;
    logic [63:0]  pp11_reg;
    logic         neg2_reg;
    logic [127:0] sum;
    logic [63:0]  mag;
    logic signed [63:0] p_reg;

    always_ff @(posedge clk)
    begin
        ma_reg   <= a[63] ? 64'(-a) : 64'(a);
        mb_reg   <= b[63] ? 64'(-b) : 64'(b);
        neg1_reg <= a[63] ^ b[63];
        pp00_reg <= ma_reg[31:0]  * mb_reg[31:0];
        pp01_reg <= ma_reg[31:0]  * mb_reg[63:32];
        pp10_reg <= ma_reg[63:32] * mb_reg[31:0];
        pp11_reg <= ma_reg[63:32] * mb_reg[63:32];
        neg2_reg <= neg1_reg;
        p_reg    <= neg2_reg ? $signed(-mag) : $signed(mag);
    end

    always_comb
    begin
        sum = {64'd0, pp00_reg} + ({64'd0, pp01_reg} << 32) + ({64'd0, pp10_reg} << 32)
            + ({pp11_reg, 64'd0}) + (128'd1 << (SH - 1));
        mag = 64'(sum >> SH);
    end

    assign p = p_reg;
endmodule

@@ src/ltu_div.sv @@
// ----------------------------------------------------------------------------
// ltu_div
// Signed division by a small constant, truncating toward zero, optionally
// negated. Reciprocal multiply, then one remainder correction.
// ----------------------------------------------------------------------------
module ltu_div #(
    parameter int DIVISOR = 6,
    parameter bit NEG = 1'b0
) (
    input  logic               clk,
    input  logic signed [63:0] x,
    output logic signed [63:0] q
);
    localparam logic [63:0] RECIP = 64'h8000_0000_0000_0000 / 64'(DIVISOR);

    logic signed [63:0] q0;
    logic [63:0]        x_d;
    logic [63:0]        q0m;
    logic [63:0]        xm;
    logic [65:0]        prod;
    logic signed [65:0] r;
    logic [63:0]        qc;
    logic signed [63:0] q_reg;

    ltu_mul #(.SH(63)) u_recip (.clk(clk), .a(x), .b($signed(RECIP)), .p(q0));
    ltu_dly #(.W(64), .N(3)) u_xd (.clk(clk), .d(x), .q(x_d));

    always_comb
    begin
        q0m  = q0[63] ? 64'(-q0) : 64'(q0);
        xm   = x_d[63] ? 64'(-x_d) : x_d;
        prod = {2'b00, q0m} * 66'(DIVISOR);
        r    = $signed({2'b00, xm}) - $signed(prod);
        if (r < 0)
        begin
            qc = q0m - 64'd1;
        end
        else if (r >= 66'sd0 + 66'(DIVISOR))
        begin
            qc = q0m + 64'd1;
        end
        else
        begin
            qc = q0m;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= (x_d[63] ^ NEG) ? $signed(-qc) : $signed(qc);
    end

    ltu_dly #(.W(64), .N(2)) u_qd (.clk(clk), .d(q_reg), .q(q));
endmodule

@@ src/ltu_trig_step.sv @@
// ----------------------------------------------------------------------------
// ltu_trig_step
// One Taylor term of the sine and cosine series: multiply by x^2, divide by
// the factorial step, accumulate.
// ----------------------------------------------------------------------------
module ltu_trig_step #(
    parameter int K = 1
) (
    input  logic            clk,
    input  ltu_pkg::trig_t  din,
    output ltu_pkg::trig_t  dout
);
    import ltu_pkg::*;

    localparam int DS = (2 * K) * (2 * K + 1);
    localparam int DC = (2 * K - 1) * (2 * K);

    logic signed [63:0] ps;
    logic signed [63:0] pc;
    logic signed [63:0] ts;
    logic signed [63:0] tc;
    logic signed [63:0] ss_d;
    logic signed [63:0] sc_d;
    logic signed [63:0] x2_d;

    ltu_mul #(.SH(QB)) u_ms (.clk(clk), .a(din.ts), .b(din.x2), .p(ps));
    ltu_mul #(.SH(QB)) u_mc (.clk(clk), .a(din.tc), .b(din.x2), .p(pc));
    ltu_div #(.DIVISOR(DS), .NEG(1'b1)) u_ds (.clk(clk), .x(ps), .q(ts));
    ltu_div #(.DIVISOR(DC), .NEG(1'b1)) u_dc (.clk(clk), .x(pc), .q(tc));
    ltu_dly #(.W(64), .N(9)) u_ss (.clk(clk), .d(din.ss), .q(ss_d));
    ltu_dly #(.W(64), .N(9)) u_sc (.clk(clk), .d(din.sc), .q(sc_d));
    ltu_dly #(.W(64), .N(9)) u_x2 (.clk(clk), .d(din.x2), .q(x2_d));

    always_comb
    begin
        dout.ts = ts;
        dout.ss = ss_d + ts;
        dout.tc = tc;
        dout.sc = sc_d + tc;
        dout.x2 = x2_d;
    end
endmodule
